FILE: src/text_mode_console_writer_defines.svh
// ----------------------------------------------------------------------------
// Text mode console writer: assertion macros
// Shared property wrappers, clocked on clk and disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef TEXT_MODE_CONSOLE_WRITER_DEFINES_SVH
`define TEXT_MODE_CONSOLE_WRITER_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define TMCW_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define TMCW_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: src/tmcw_pkg.sv
// ----------------------------------------------------------------------------
// Text mode console writer package
// Command and response item types and fixed codes of the console.
// ----------------------------------------------------------------------------
`default_nettype none

package tmcw_pkg;

    typedef struct packed {
        logic [2:0] func;
        logic [7:0] char_code;
        logic [4:0] row;
        logic [6:0] col;
        logic [3:0] fore_color;
        logic [3:0] back_color;
    } cmd_t;

    typedef struct packed {
        logic [4:0]  cursor_row;
        logic [6:0]  cursor_col;
        logic [10:0] hw_cursor_pos;
        logic [7:0]  cell_char;
        logic [7:0]  cell_attr;
        logic        scrolled;
    } rsp_t;

    localparam logic [2:0] FUNC_PUT    = 3'd0;
    localparam logic [2:0] FUNC_PUT_AT = 3'd1;
    localparam logic [2:0] FUNC_CLEAR  = 3'd2;
    localparam logic [2:0] FUNC_SETCOL = 3'd3;
    localparam logic [2:0] FUNC_READ   = 3'd4;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_BS    = 8'h08;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;

    localparam logic [7:0] ATTR_RESET = 8'h1F;
    localparam int         TAB_STEP   = 8;

endpackage

`default_nettype wire

FILE: src/tmcw_ram.sv
// ----------------------------------------------------------------------------
// Text mode console writer RAM
// Single port synchronous RAM with a registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module tmcw_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2000
) (
    input  wire logic                     clk,
    input  wire logic                     en,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (we)
            begin
                mem[addr] <= wdata;
            end
            else
            begin
                rdata <= mem[addr];
            end
        end
    end

endmodule

`default_nettype wire

FILE: src/text_mode_console_writer.sv
// ----------------------------------------------------------------------------
// Text mode console writer
// Character-cell console with cursor, wrap, scroll and colour handling.
// ----------------------------------------------------------------------------
// Usage: a command item is taken when start is high and busy is low. Each
// command gives one response item, shown on rsp for the single cycle in
// which done is high; the receiver cannot stall it, so it must take it then.
// Path from acceptance to done, with C = COLUMNS and R = ROWS:
//   put / put-at, printable, or backspace off column 0   PUT, PHYS, ADDR, WRITE, WRAP, BOTTOM, CRT
//   put / put-at, any other byte                          PUT, WRAP, BOTTOM, CRT
//   either of these with a scroll                         then PHYS, ADDR, SCROLL over C cells, CRT
//   read cell                                             PHYS, ADDR, READ, WAIT
//   set colours and unused codes                          straight to DONE
//   clear                                                 CLEAR over all R * C cells
// Every cell access goes through the one RAM port and every put, read or
// cursor position is formed by one shared row * C + column unit, so the
// sequencer steps through them one at a time. A scroll blanks a row at one
// cell per cycle and clear fills the screen at one cell per cycle. After
// reset the block is busy while it blanks the screen, then takes commands.
// The character store holds bytes only: every cell always carries the
// current attribute, which is why recolouring needs no pass over the cells.
// ----------------------------------------------------------------------------
`default_nettype none

`include "text_mode_console_writer_defines.svh"

module text_mode_console_writer #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           start,
    output logic                busy,
    input  wire tmcw_pkg::cmd_t cmd,
    output logic                done,
    output tmcw_pkg::rsp_t      rsp
);

    import tmcw_pkg::*;

    localparam int NCELLS = ROWS * COLUMNS;
    localparam int AW     = $clog2(NCELLS);
    localparam int RW     = $clog2(ROWS);
    localparam int RW1    = $clog2(ROWS + 1);
    localparam int CW     = $clog2(COLUMNS);
    localparam int CW1    = $clog2(COLUMNS + TAB_STEP);
    localparam int MW     = $clog2((ROWS + 1) * COLUMNS + COLUMNS + TAB_STEP);

    typedef enum logic [12:0] {
        S_IDLE   = 13'b0000000000001,
        S_CLEAR  = 13'b0000000000010,
        S_PUT    = 13'b0000000000100,
        S_PHYS   = 13'b0000000001000,
        S_ADDR   = 13'b0000000010000,
        S_WRITE  = 13'b0000000100000,
        S_READ   = 13'b0000001000000,
        S_WAIT   = 13'b0000010000000,
        S_WRAP   = 13'b0000100000000,
        S_BOTTOM = 13'b0001000000000,
        S_SCROLL = 13'b0010000000000,
        S_CRT    = 13'b0100000000000,
        S_DONE   = 13'b1000000000000
    } state_t;

    state_t         state_reg, state_next;
    logic [RW-1:0]  top_reg, top_next;
    logic [RW-1:0]  cur_row_reg, cur_row_next;
    logic [CW-1:0]  cur_col_reg, cur_col_next;
    logic [7:0]     attr_reg, attr_next;
    logic [10:0]    crt_reg, crt_next;
    logic [AW-1:0]  sweep_reg, sweep_next;
    logic [2:0]     func_reg, func_next;

    logic [RW1-1:0] w_row_reg, w_row_next;
    logic [CW1-1:0] w_col_reg, w_col_next;
    logic [RW-1:0]  phys_reg, phys_next;
    logic [AW-1:0]  addr_reg, addr_next;
    logic [7:0]     ch_reg, ch_next;
    logic [7:0]     wr_char_reg, wr_char_next;
    logic           inc_reg, inc_next;
    logic [7:0]     rd_char_reg, rd_char_next;
    logic           scrolled_reg, scrolled_next;

    logic           ram_en, ram_we;
    logic [AW-1:0]  ram_addr;
    logic [7:0]     ram_wdata, ram_rdata;

    logic [RW1-1:0] mac_a;
    logic [MW-1:0]  mac_res;
    logic [RW:0]    phys_sum;
    logic [CW1-1:0] tab_sum;
    logic [RW1-1:0] sat_row;
    logic [CW1-1:0] sat_col;
    logic           accept;
    logic           cursor_on_screen;
    logic           setcol_accept;

    tmcw_ram #(
        .WIDTH (8),
        .DEPTH (NCELLS)
    ) u_ram (
        .clk   (clk),
        .en    (ram_en),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    // Shared position unit: row * COLUMNS + column.
    assign mac_a   = (state_reg == S_CRT) ? w_row_reg : RW1'(phys_reg);
    assign mac_res = MW'(mac_a) * MW'(COLUMNS) + MW'(w_col_reg);

    assign phys_sum = {1'b0, top_reg} + (RW + 1)'(w_row_reg);
    assign tab_sum  = w_col_reg + CW1'(TAB_STEP);
    assign sat_row  = (32'(cmd.row) >= ROWS) ? RW1'(ROWS - 1) : RW1'(cmd.row);
    assign sat_col  = (32'(cmd.col) >= COLUMNS) ? CW1'(COLUMNS - 1) : CW1'(cmd.col);

    assign busy   = (state_reg != S_IDLE);
    assign accept = start && !busy;
    assign done   = (state_reg == S_DONE);

    assign cursor_on_screen = (32'(cur_row_reg) < ROWS) && (32'(cur_col_reg) < COLUMNS);
    assign setcol_accept    = accept && (cmd.func == FUNC_SETCOL);

    always_comb
    begin
        state_next    = state_reg;
        top_next      = top_reg;
        cur_row_next  = cur_row_reg;
        cur_col_next  = cur_col_reg;
        attr_next     = attr_reg;
        crt_next      = crt_reg;
        sweep_next    = sweep_reg;
        func_next     = func_reg;
        w_row_next    = w_row_reg;
        w_col_next    = w_col_reg;
        phys_next     = phys_reg;
        addr_next     = addr_reg;
        ch_next       = ch_reg;
        wr_char_next  = wr_char_reg;
        inc_next      = inc_reg;
        rd_char_next  = rd_char_reg;
        scrolled_next = scrolled_reg;
        ram_en        = 1'b0;
        ram_we        = 1'b0;
        ram_addr      = addr_reg;
        ram_wdata     = CH_SPACE;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    func_next     = cmd.func;
                    ch_next       = cmd.char_code;
                    scrolled_next = 1'b0;
                    rd_char_next  = CH_NUL;
                    case (cmd.func)
                        FUNC_PUT:
                        begin
                            w_row_next = RW1'(cur_row_reg);
                            w_col_next = CW1'(cur_col_reg);
                            state_next = S_PUT;
                        end
                        FUNC_PUT_AT:
                        begin
                            w_row_next = sat_row;
                            w_col_next = sat_col;
                            state_next = S_PUT;
                        end
                        FUNC_CLEAR:
                        begin
                            top_next     = '0;
                            cur_row_next = '0;
                            cur_col_next = '0;
                            crt_next     = '0;
                            sweep_next   = '0;
                            state_next   = S_CLEAR;
                        end
                        FUNC_SETCOL:
                        begin
                            attr_next  = {cmd.back_color, cmd.fore_color};
                            state_next = S_DONE;
                        end
                        FUNC_READ:
                        begin
                            w_row_next = sat_row;
                            w_col_next = sat_col;
                            state_next = S_PHYS;
                        end
                        default:
                        begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end

            S_CLEAR:
            begin
                ram_en   = 1'b1;
                ram_we   = 1'b1;
                ram_addr = sweep_reg;
                if (sweep_reg == AW'(NCELLS - 1))
                begin
                    // The pass after reset ends silently; a clear command reports.
                    state_next = (func_reg == FUNC_CLEAR) ? S_DONE : S_IDLE;
                end
                else
                begin
                    sweep_next = sweep_reg + 1'b1;
                end
            end

            S_PUT:
            begin
                state_next = S_WRAP;
                if (ch_reg == CH_BS)
                begin
                    if (w_col_reg != '0)
                    begin
                        w_col_next   = w_col_reg - 1'b1;
                        wr_char_next = CH_NUL;
                        inc_next     = 1'b0;
                        state_next   = S_PHYS;
                    end
                end
                else if (ch_reg == CH_TAB)
                begin
                    w_col_next = {tab_sum[CW1-1:3], 3'b000};
                end
                else if (ch_reg == CH_CR)
                begin
                    w_col_next = '0;
                end
                else if (ch_reg == CH_LF)
                begin
                    w_col_next = '0;
                    w_row_next = w_row_reg + 1'b1;
                end
                else if (ch_reg >= CH_SPACE)
                begin
                    wr_char_next = ch_reg;
                    inc_next     = 1'b1;
                    state_next   = S_PHYS;
                end
            end

            S_PHYS:
            begin
                if (phys_sum >= (RW + 1)'(ROWS))
                begin
                    phys_next = RW'(phys_sum - (RW + 1)'(ROWS));
                end
                else
                begin
                    phys_next = RW'(phys_sum);
                end
                state_next = S_ADDR;
            end

            S_ADDR:
            begin
                addr_next = AW'(mac_res);
                if (scrolled_reg)
                begin
                    state_next = S_SCROLL;
                end
                else if (func_reg == FUNC_READ)
                begin
                    state_next = S_READ;
                end
                else
                begin
                    state_next = S_WRITE;
                end
            end

            S_WRITE:
            begin
                ram_en     = 1'b1;
                ram_we     = 1'b1;
                ram_wdata  = wr_char_reg;
                w_col_next = w_col_reg + CW1'(inc_reg);
                state_next = S_WRAP;
            end

            S_READ:
            begin
                ram_en     = 1'b1;
                state_next = S_WAIT;
            end

            S_WAIT:
            begin
                rd_char_next = ram_rdata;
                state_next   = S_DONE;
            end

            S_WRAP:
            begin
                if (w_col_reg >= CW1'(COLUMNS))
                begin
                    w_col_next = '0;
                    w_row_next = w_row_reg + 1'b1;
                end
                state_next = S_BOTTOM;
            end

            S_BOTTOM:
            begin
                if (w_row_reg >= RW1'(ROWS))
                begin
                    // Only a line feed or a wrap gets here, so the column is
                    // already 0, which is where the blanking starts.
                    top_next      = (top_reg == RW'(ROWS - 1)) ? '0 : top_reg + 1'b1;
                    w_row_next    = RW1'(ROWS - 1);
                    scrolled_next = 1'b1;
                    sweep_next    = '0;
                    state_next    = S_PHYS;
                end
                else
                begin
                    state_next = S_CRT;
                end
            end

            S_SCROLL:
            begin
                ram_en    = 1'b1;
                ram_we    = 1'b1;
                addr_next = addr_reg + 1'b1;
                if (sweep_reg == AW'(COLUMNS - 1))
                begin
                    state_next = S_CRT;
                end
                else
                begin
                    sweep_next = sweep_reg + 1'b1;
                end
            end

            S_CRT:
            begin
                crt_next = 11'(mac_res);
                // Put-at leaves the cursor where it was.
                if (func_reg == FUNC_PUT)
                begin
                    cur_row_next = RW'(w_row_reg);
                    cur_col_next = CW'(w_col_reg);
                end
                state_next = S_DONE;
            end

            S_DONE:
            begin
                state_next = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_CLEAR;
            top_reg     <= '0;
            cur_row_reg <= '0;
            cur_col_reg <= '0;
            attr_reg    <= ATTR_RESET;
            crt_reg     <= '0;
            sweep_reg   <= '0;
            func_reg    <= FUNC_PUT;
        end
        else
        begin
            state_reg   <= state_next;
            top_reg     <= top_next;
            cur_row_reg <= cur_row_next;
            cur_col_reg <= cur_col_next;
            attr_reg    <= attr_next;
            crt_reg     <= crt_next;
            sweep_reg   <= sweep_next;
            func_reg    <= func_next;
        end
    end

    always_ff @(posedge clk)
    begin
        w_row_reg    <= w_row_next;
        w_col_reg    <= w_col_next;
        phys_reg     <= phys_next;
        addr_reg     <= addr_next;
        ch_reg       <= ch_next;
        wr_char_reg  <= wr_char_next;
        inc_reg      <= inc_next;
        rd_char_reg  <= rd_char_next;
        scrolled_reg <= scrolled_next;
    end

    assign rsp.cursor_row    = 5'(cur_row_reg);
    assign rsp.cursor_col    = 7'(cur_col_reg);
    assign rsp.hw_cursor_pos = crt_reg;
    assign rsp.cell_char     = rd_char_reg;
    assign rsp.cell_attr     = (func_reg == FUNC_READ) ? attr_reg : 8'h00;
    assign rsp.scrolled      = scrolled_reg;

    `TMCW_ASSERT_NEXT(a_done_single, done, !done, "response strobe held for more than one cycle")
    `TMCW_ASSERT_NEXT(a_accept_busy, accept, busy, "accepted item did not make the block busy")
    `TMCW_ASSERT_NOW(a_cursor_range, 1'b1, cursor_on_screen, "stored cursor left the screen")
    `TMCW_ASSERT_NEXT(a_attr_hold, !setcol_accept, $stable(attr_reg), "attribute changed alone")
    `TMCW_ASSERT_NOW(a_ram_write_busy, ram_we, busy && ram_en, "cell store written while idle")

endmodule

`default_nettype wire
